// ===== design/pfe_pkg.sv =====
// Shared types, constants and color math for the palette fade engine.
// No dependencies; every other design file but pfe_ram refers to this package by scoped names.
package pfe_pkg;

  // Color store depth (power of two, 8 to 1024).
  localparam int COLORS = 128;
  localparam int IDX_W  = $clog2(COLORS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int MONO_SLOTS = 3;
  localparam logic [4:0] STEP_RESET = 5'd4;
  localparam logic [1:0] MONO_SLOT_MAX = 2'd2;

  typedef enum logic [2:0] {
    OP_WR_CUR      = 3'd0,
    OP_WR_TGT      = 3'd1,
    OP_WR_MONO_CUR = 3'd2,
    OP_WR_MONO_TGT = 3'd3,
    OP_FADE        = 3'd4,
    OP_FADE_MONO   = 3'd5,
    OP_RD          = 3'd6,
    OP_RD_MONO     = 3'd7
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [7:0]       cnt;
    logic [14:0]      color;
    logic [7:0]       shade;
    logic [1:0]       slot;
    logic [4:0]       step;
  } req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] color;
    logic [7:0]  shade;
    logic        differs;
  } rsp_t;

  // Shade mix table, indexed by {current shade, target shade}.
  localparam logic [1:0] MIX_TABLE [16] = '{
    2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2,
    2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd2, 2'd2, 2'd3
  };

  function automatic logic [4:0] move_toward(logic [4:0] v, logic [4:0] t, logic [4:0] step);
    logic [4:0] d;
    logic [4:0] r;
    r = v;
    if (v < t) begin
      d = t - v;
      r = v + ((d > step) ? step : d);
    end else if (v > t) begin
      d = v - t;
      r = v - ((d > step) ? step : d);
    end
    return r;
  endfunction

  function automatic logic [14:0] fade_color(logic [14:0] cur, logic [14:0] tgt,
                                             logic [4:0] step);
    return {move_toward(cur[14:10], tgt[14:10], step),
            move_toward(cur[9:5], tgt[9:5], step),
            move_toward(cur[4:0], tgt[4:0], step)};
  endfunction

  function automatic logic [7:0] mix_byte(logic [7:0] cur, logic [7:0] tgt);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[2*k +: 2] = MIX_TABLE[{cur[2*k +: 2], tgt[2*k +: 2]}];
    end
    return r;
  endfunction

endpackage

// ===== design/palette_fade_engine.sv =====
// Palette fade engine top: stream ports, fade step register, result queue, checks.
// Depends on pfe_pkg, pfe_ctrl (with pfe_ram) and pfe_mono.
// A write or mono item registers its result from the accept; a color read passes
// through the RAM read register and S_WAIT; a color fade walks count entries (count
// after saturation, one entry per cycle through the read-modify-write port of the
// current color RAM) in S_RUN, then S_DRAIN. Items run one at a time; the next item is
// taken once busy clears behind the previous result and the queue has room. Reset is
// asynchronous, active low: control clears, fade step returns to 4, RAMs and mono palettes keep no reset value.
module palette_fade_engine (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] index, [14:7] count, [29:15] color, [37:30] shade_byte, [39:38] mono_slot
  input  logic [39:0] s_axis_tdata,
  // [2:0] op
  input  logic [2:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] color_out, [22:15] shade_out, [23] differs
  output logic [23:0] m_axis_tdata,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  logic          in_acc;
  logic          out_acc;
  logic          busy_q;
  logic [4:0]    step_q;
  pfe_pkg::req_t req;
  pfe_pkg::rsp_t ctrl_rsp;
  pfe_pkg::rsp_t mono_rsp;
  pfe_pkg::rsp_t rsp;

  // Two-slot result queue decouples the core from output stalls.
  logic [23:0]   q_data_q [2];
  logic          q_wr_q;
  logic          q_rd_q;
  logic [1:0]    q_cnt_q;

  // Take a new item only when no item is in flight and the queue has room.
  assign s_axis_tready = !busy_q && (q_cnt_q != 2'd2);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Unpack the item; index wraps modulo the store depth.
  always_comb begin
    req       = '0;
    req.op    = pfe_pkg::op_e'(s_axis_tuser);
    req.idx   = pfe_pkg::IDX_W'(s_axis_tdata[6:0]);
    req.cnt   = s_axis_tdata[14:7];
    req.color = s_axis_tdata[29:15];
    req.shade = s_axis_tdata[37:30];
    req.slot  = s_axis_tdata[39:38];
    req.step  = step_q;
  end

  // Both units see every accepted item and act only on their own ops.
  pfe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .req_i   (req),
    .rsp_o   (ctrl_rsp)
  );

  pfe_mono u_mono (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .req_i   (req),
    .rsp_o   (mono_rsp)
  );

  // Unused fields of each unit's result are zero, so OR merges them.
  assign rsp = ctrl_rsp | mono_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pfe_pkg::STEP_RESET;
      busy_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_data_i;
      end
      // Hold busy from accept until the result reaches the queue.
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (rsp.done) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Queue payload, no reset.
  always_ff @(posedge clk_i) begin
    if (rsp.done) begin
      q_data_q[q_wr_q] <= {rsp.differs, rsp.shade, rsp.color};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= 1'b0;
      q_rd_q  <= 1'b0;
      q_cnt_q <= 2'd0;
    end else begin
      if (rsp.done) begin
        q_wr_q <= ~q_wr_q;
      end
      if (out_acc) begin
        q_rd_q <= ~q_rd_q;
      end
      case ({rsp.done, out_acc})
        2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
        2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
        default: q_cnt_q <= q_cnt_q;
      endcase
    end
  end

  assign m_axis_tvalid = (q_cnt_q != 2'd0);
  assign m_axis_tdata  = q_data_q[q_rd_q];

  // A result appears only for an item in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> busy_q)
    else $error("result without an item in flight");

  // The two units never finish in the same cycle.
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_rsp.done && mono_rsp.done))
    else $error("both units finished together");

  // The queue never overfills.
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q != 2'd3) && !(rsp.done && q_cnt_q == 2'd2 && !out_acc))
    else $error("result queue overflow");

  // An accepted item always keeps the core busy the next cycle.
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q)
    else $error("accepted item not tracked");

endmodule

// ===== design/pfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfe_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/pfe_ctrl.sv =====
// Color store sequencer: current and target RAMs, writes, reads and the fade walk.
// Depends on pfe_pkg and pfe_ram.
module pfe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pfe_pkg::req_t req_i,
  output pfe_pkg::rsp_t rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_WAIT
  } state_e;

  state_e                    state_q;
  logic [pfe_pkg::IDX_W-1:0] addr_q;
  logic [pfe_pkg::IDX_W-1:0] wb_addr_q;
  logic [pfe_pkg::CNT_W-1:0] left_q;
  logic                      rd_vld_q;
  logic                      diff_q;
  logic [4:0]                step_q;
  pfe_pkg::rsp_t             rsp_q;

  logic [8:0]                cnt_full;
  logic [pfe_pkg::CNT_W-1:0] cnt_eff;
  logic [pfe_pkg::IDX_W-1:0] addr_next;
  logic                      cur_we;
  logic [pfe_pkg::IDX_W-1:0] cur_waddr;
  logic [14:0]               cur_wdata;
  logic                      tgt_we;
  logic                      rd_en;
  logic [pfe_pkg::IDX_W-1:0] raddr;
  logic [14:0]               cur_rdata;
  logic [14:0]               tgt_rdata;
  logic [14:0]               faded;
  logic                      diff_now;

  // Count zero stands for 256; saturate to the store depth.
  assign cnt_full = (req_i.cnt == 8'd0) ? 9'd256 : {1'b0, req_i.cnt};
  assign cnt_eff  = (int'(cnt_full) > pfe_pkg::COLORS) ?
                    pfe_pkg::CNT_W'(pfe_pkg::COLORS) : pfe_pkg::CNT_W'(cnt_full);

  assign addr_next = (addr_q == pfe_pkg::IDX_W'(pfe_pkg::COLORS - 1)) ?
                     '0 : addr_q + pfe_pkg::IDX_W'(1);

  assign faded    = pfe_pkg::fade_color(cur_rdata, tgt_rdata, step_q);
  assign diff_now = rd_vld_q && (faded != tgt_rdata);

  always_comb begin
    cur_we    = rd_vld_q || (start_i && (req_i.op == pfe_pkg::OP_WR_CUR));
    cur_waddr = rd_vld_q ? wb_addr_q : req_i.idx;
    cur_wdata = rd_vld_q ? faded : req_i.color;
    tgt_we    = start_i && (req_i.op == pfe_pkg::OP_WR_TGT);
    rd_en     = (state_q == S_RUN) || (start_i && (req_i.op == pfe_pkg::OP_RD));
    raddr     = (state_q == S_RUN) ? addr_q : req_i.idx;
  end

  pfe_ram #(.WIDTH(15), .DEPTH(pfe_pkg::COLORS)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (cur_rdata)
  );

  pfe_ram #(.WIDTH(15), .DEPTH(pfe_pkg::COLORS)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (req_i.idx),
    .wdata_i (req_i.color),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (tgt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      addr_q    <= '0;
      wb_addr_q <= '0;
      left_q    <= '0;
      rd_vld_q  <= 1'b0;
      diff_q    <= 1'b0;
      step_q    <= '0;
      rsp_q     <= '0;
    end else begin
      rsp_q    <= '0;
      rd_vld_q <= (state_q == S_RUN);
      if (rd_vld_q) begin
        diff_q <= diff_q | diff_now;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            unique case (req_i.op)
              pfe_pkg::OP_WR_CUR, pfe_pkg::OP_WR_TGT: begin
                rsp_q.done <= 1'b1;
              end
              pfe_pkg::OP_FADE: begin
                addr_q  <= req_i.idx;
                left_q  <= cnt_eff;
                diff_q  <= 1'b0;
                step_q  <= req_i.step;
                state_q <= S_RUN;
              end
              pfe_pkg::OP_RD: begin
                state_q <= S_WAIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          wb_addr_q <= addr_q;
          addr_q    <= addr_next;
          left_q    <= left_q - pfe_pkg::CNT_W'(1);
          if (left_q == pfe_pkg::CNT_W'(1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          rsp_q.done    <= 1'b1;
          rsp_q.differs <= diff_q | diff_now;
          state_q       <= S_IDLE;
        end
        S_WAIT: begin
          rsp_q.done  <= 1'b1;
          rsp_q.color <= cur_rdata;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== design/pfe_mono.sv =====
// Mono palette registers: write, read back and the three-palette mix fade.
// Depends on pfe_pkg.
module pfe_mono (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pfe_pkg::req_t req_i,
  output pfe_pkg::rsp_t rsp_o
);

  logic [7:0]    cur_q [pfe_pkg::MONO_SLOTS];
  logic [7:0]    tgt_q [pfe_pkg::MONO_SLOTS];
  logic [7:0]    mixed [pfe_pkg::MONO_SLOTS];
  logic          mix_diff;
  logic          slot_ok;
  pfe_pkg::rsp_t rsp_q;

  assign slot_ok = (req_i.slot <= pfe_pkg::MONO_SLOT_MAX);

  always_comb begin
    mix_diff = 1'b0;
    for (int i = 0; i < pfe_pkg::MONO_SLOTS; i++) begin
      mixed[i] = pfe_pkg::mix_byte(cur_q[i], tgt_q[i]);
      mix_diff = mix_diff | (mixed[i] != tgt_q[i]);
    end
  end

  // Palette contents carry no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      case (req_i.op)
        pfe_pkg::OP_WR_MONO_CUR: if (slot_ok) cur_q[req_i.slot] <= req_i.shade;
        pfe_pkg::OP_WR_MONO_TGT: if (slot_ok) tgt_q[req_i.slot] <= req_i.shade;
        pfe_pkg::OP_FADE_MONO: begin
          for (int i = 0; i < pfe_pkg::MONO_SLOTS; i++) begin
            cur_q[i] <= mixed[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '0;
    end else begin
      rsp_q <= '0;
      if (start_i) begin
        case (req_i.op)
          pfe_pkg::OP_WR_MONO_CUR, pfe_pkg::OP_WR_MONO_TGT: rsp_q.done <= 1'b1;
          pfe_pkg::OP_FADE_MONO: begin
            rsp_q.done    <= 1'b1;
            rsp_q.differs <= mix_diff;
          end
          pfe_pkg::OP_RD_MONO: begin
            rsp_q.done  <= 1'b1;
            rsp_q.shade <= slot_ok ? cur_q[req_i.slot] : 8'd0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== sim/tb_palette_fade_engine.sv =====
// Self-checking testbench for palette_fade_engine: drives random and directed items
// through the stream ports, mirrors the palettes in a scoreboard class and checks every result.
// Depends on pfe_pkg and design/palette_fade_engine.sv.
module tb_palette_fade_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 1_200_000;
  localparam int ITEMS_PER_PHASE = 196;
  localparam int PHASES          = 6;
  // Settle margin covers the longest color fade, with count saturated to the store depth.
  localparam int SETTLE_CYCLES   = pfe_pkg::COLORS + 32;

  // Shade mix lookup, indexed by {current shade, target shade}.
  localparam logic [1:0] SHADE_MIX [16] = '{
    2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2,
    2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd2, 2'd2, 2'd3
  };

  typedef struct {
    logic [14:0] color;
    logic [7:0]  shade;
    logic        differs;
  } fade_rsp_t;

  // Mirror of both palettes plus the fade step; predicts one result per item
  // and holds the results still owed by the block.
  class palette_mirror;
    logic [14:0] cur_col [pfe_pkg::COLORS];
    logic [14:0] tgt_col [pfe_pkg::COLORS];
    logic [7:0]  mono_cur [pfe_pkg::MONO_SLOTS];
    logic [7:0]  mono_tgt [pfe_pkg::MONO_SLOTS];
    logic [4:0]  step = pfe_pkg::STEP_RESET;
    fade_rsp_t   owed[$];
    int          errors = 0;
    int          still_off = 0;
    int          on_target = 0;

    // Move one 5-bit component toward its target by at most step.
    function logic [4:0] ease(logic [4:0] v, logic [4:0] t);
      int delta;
      delta = int'(t) - int'(v);
      if (delta > int'(step)) delta = int'(step);
      else if (delta < -int'(step)) delta = -int'(step);
      return 5'(int'(v) + delta);
    endfunction

    function logic [7:0] blend_shades(logic [7:0] cur, logic [7:0] tgt);
      logic [7:0] mixed;
      mixed = '0;
      for (int k = 0; k < 4; k++) begin
        mixed[2*k +: 2] = SHADE_MIX[{cur[2*k +: 2], tgt[2*k +: 2]}];
      end
      return mixed;
    endfunction

    function void absorb_item(pfe_pkg::op_e op, logic [6:0] idx, logic [7:0] cnt,
                              logic [14:0] color, logic [7:0] shade, logic [1:0] slot);
      fade_rsp_t rsp;
      int        span;
      int        e;
      logic [14:0] c;
      logic [14:0] t;
      rsp = '{color: '0, shade: '0, differs: 1'b0};
      case (op)
        pfe_pkg::OP_WR_CUR: cur_col[idx] = color;
        pfe_pkg::OP_WR_TGT: tgt_col[idx] = color;
        pfe_pkg::OP_WR_MONO_CUR: if (slot <= pfe_pkg::MONO_SLOT_MAX) mono_cur[slot] = shade;
        pfe_pkg::OP_WR_MONO_TGT: if (slot <= pfe_pkg::MONO_SLOT_MAX) mono_tgt[slot] = shade;
        pfe_pkg::OP_FADE: begin
          // Zero count means 256; anything past the store depth walks it once.
          span = (cnt == 0) ? 256 : int'(cnt);
          if (span > pfe_pkg::COLORS) span = pfe_pkg::COLORS;
          for (int i = 0; i < span; i++) begin
            e = (int'(idx) + i) % pfe_pkg::COLORS;
            c = cur_col[e];
            t = tgt_col[e];
            cur_col[e] = {ease(c[14:10], t[14:10]), ease(c[9:5], t[9:5]), ease(c[4:0], t[4:0])};
            if (cur_col[e] != t) rsp.differs = 1'b1;
          end
        end
        pfe_pkg::OP_FADE_MONO: begin
          // All three mono palettes fade together; slot plays no part.
          for (int s = 0; s < pfe_pkg::MONO_SLOTS; s++) begin
            mono_cur[s] = blend_shades(mono_cur[s], mono_tgt[s]);
            if (mono_cur[s] != mono_tgt[s]) rsp.differs = 1'b1;
          end
        end
        pfe_pkg::OP_RD: rsp.color = cur_col[idx];
        default: if (slot <= pfe_pkg::MONO_SLOT_MAX) rsp.shade = mono_cur[slot];
      endcase
      if (op == pfe_pkg::OP_FADE || op == pfe_pkg::OP_FADE_MONO) begin
        if (rsp.differs) still_off++;
        else on_target++;
      end
      owed.push_back(rsp);
    endfunction

    function void check_rsp(logic [23:0] word);
      fade_rsp_t want;
      if (owed.size() == 0) begin
        $error("result 0x%06h arrived with no item pending", word);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (word[14:0] !== want.color) begin
        $error("color_out: expected 0x%04h, got 0x%04h", want.color, word[14:0]);
        errors++;
      end
      if (word[22:15] !== want.shade) begin
        $error("shade_out: expected 0x%02h, got 0x%02h", want.shade, word[22:15]);
        errors++;
      end
      if (word[23] !== want.differs) begin
        $error("differs: expected %0b, got %0b", want.differs, word[23]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  palette_mirror mirror = new();

  // Written-entry flags: reads and fades only ever touch entries set here.
  bit cur_set [pfe_pkg::COLORS];
  bit tgt_set [pfe_pkg::COLORS];
  bit mono_cur_set [pfe_pkg::MONO_SLOTS];
  bit mono_tgt_set [pfe_pkg::MONO_SLOTS];

  bit calm = 1'b0;       // suppress idling on both sides while set
  int cycles = 0;
  int stall_left = 0;
  int op_seen [8];
  int step_settings = 1;

  palette_fade_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none at all in calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: check each accepted result, then pick the next tready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) mirror.check_rsp(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
      end
    end
  end

  // Present one item, hold it until accepted, then record it in the mirror.
  task automatic issue(pfe_pkg::op_e op, logic [6:0] idx, logic [7:0] cnt,
                       logic [14:0] color, logic [7:0] shade, logic [1:0] slot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {slot, shade, color, cnt, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.absorb_item(op, idx, cnt, color, shade, slot);
    op_seen[op]++;
    case (op)
      pfe_pkg::OP_WR_CUR: cur_set[idx] = 1'b1;
      pfe_pkg::OP_WR_TGT: tgt_set[idx] = 1'b1;
      pfe_pkg::OP_WR_MONO_CUR: if (slot <= pfe_pkg::MONO_SLOT_MAX) mono_cur_set[slot] = 1'b1;
      pfe_pkg::OP_WR_MONO_TGT: if (slot <= pfe_pkg::MONO_SLOT_MAX) mono_tgt_set[slot] = 1'b1;
      default: ;
    endcase
  endtask

  // Drop tvalid and hold until every owed result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (mirror.owed.size() != 0) @(posedge clk_i);
  endtask

  // Write the fade step only with the block idle.
  task automatic set_step(logic [4:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mirror.step = value;
    step_settings++;
  endtask

  function automatic logic [6:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    // Crowd a small window so repeated fades converge, and the top for wrap.
    if (r < 45) return 7'($urandom_range(0, 15));
    if (r < 60) return 7'($urandom_range(pfe_pkg::COLORS - 8, pfe_pkg::COLORS - 1));
    return 7'($urandom_range(0, pfe_pkg::COLORS - 1));
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(1, 12));
    if (r < 85) return 8'($urandom_range(13, 127));
    if (r < 95) return 8'($urandom_range(128, 255));
    return 8'd0;
  endfunction

  // Random item; a read or fade that would touch an unwritten entry becomes
  // a write of that entry instead, which fills the stores as the run goes.
  task automatic random_item();
    pfe_pkg::op_e op;
    logic [6:0]  idx;
    logic [7:0]  cnt;
    logic [14:0] color;
    logic [7:0]  shade;
    logic [1:0]  slot;
    int          r;
    int          span;
    int          e;
    r = $urandom_range(0, 99);
    if (r < 14) op = pfe_pkg::OP_WR_CUR;
    else if (r < 28) op = pfe_pkg::OP_WR_TGT;
    else if (r < 34) op = pfe_pkg::OP_WR_MONO_CUR;
    else if (r < 40) op = pfe_pkg::OP_WR_MONO_TGT;
    else if (r < 65) op = pfe_pkg::OP_FADE;
    else if (r < 73) op = pfe_pkg::OP_FADE_MONO;
    else if (r < 90) op = pfe_pkg::OP_RD;
    else op = pfe_pkg::OP_RD_MONO;
    idx   = pick_index();
    cnt   = (op == pfe_pkg::OP_FADE) ? pick_count() : 8'($urandom_range(0, 255));
    color = 15'($urandom_range(0, 32767));
    shade = 8'($urandom_range(0, 255));
    slot  = 2'($urandom_range(0, 3));
    case (op)
      pfe_pkg::OP_FADE: begin
        span = (cnt == 0) ? 256 : int'(cnt);
        if (span > pfe_pkg::COLORS) span = pfe_pkg::COLORS;
        for (int i = 0; i < span; i++) begin
          e = (int'(idx) + i) % pfe_pkg::COLORS;
          if (!cur_set[e]) begin
            op  = pfe_pkg::OP_WR_CUR;
            idx = 7'(e);
            break;
          end
          if (!tgt_set[e]) begin
            op  = pfe_pkg::OP_WR_TGT;
            idx = 7'(e);
            break;
          end
        end
      end
      pfe_pkg::OP_FADE_MONO: begin
        for (int s = 0; s < pfe_pkg::MONO_SLOTS; s++) begin
          if (!mono_cur_set[s]) begin
            op   = pfe_pkg::OP_WR_MONO_CUR;
            slot = 2'(s);
            break;
          end
          if (!mono_tgt_set[s]) begin
            op   = pfe_pkg::OP_WR_MONO_TGT;
            slot = 2'(s);
            break;
          end
        end
      end
      pfe_pkg::OP_RD: if (!cur_set[idx]) op = pfe_pkg::OP_WR_CUR;
      pfe_pkg::OP_RD_MONO: begin
        if (slot <= pfe_pkg::MONO_SLOT_MAX && !mono_cur_set[slot]) begin
          op = pfe_pkg::OP_WR_MONO_CUR;
        end
      end
      default: ;
    endcase
    issue(op, idx, cnt, color, shade, slot);
  endtask

  initial begin
    int value;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset fade step.
    // Full-range climb on entry zero, one entry walked.
    issue(pfe_pkg::OP_WR_CUR, 7'd0, 8'd1, 15'h0000, 8'h00, 2'd0);
    issue(pfe_pkg::OP_WR_TGT, 7'd0, 8'd1, 15'h7fff, 8'hff, 2'd3);
    issue(pfe_pkg::OP_FADE,   7'd0, 8'd1, 15'h7fff, 8'hff, 2'd3);
    issue(pfe_pkg::OP_RD,     7'd0, 8'hff, 15'h7fff, 8'hff, 2'd3);
    // Descent at the top entry, with the walk wrapping back to entry zero.
    issue(pfe_pkg::OP_WR_CUR, 7'd127, 8'd0, 15'h7fff, 8'h00, 2'd0);
    issue(pfe_pkg::OP_WR_TGT, 7'd127, 8'd0, 15'h0000, 8'h00, 2'd0);
    issue(pfe_pkg::OP_FADE,   7'd127, 8'd2, 15'h0000, 8'h00, 2'd0);
    issue(pfe_pkg::OP_RD,     7'd127, 8'd0, 15'h0000, 8'h00, 2'd0);
    issue(pfe_pkg::OP_RD,     7'd0, 8'd0, 15'h0000, 8'h00, 2'd0);
    // An entry already on target reports no difference.
    issue(pfe_pkg::OP_WR_CUR, 7'd5, 8'd1, 15'h1234, 8'h5a, 2'd1);
    issue(pfe_pkg::OP_WR_TGT, 7'd5, 8'd1, 15'h1234, 8'ha5, 2'd2);
    issue(pfe_pkg::OP_FADE,   7'd5, 8'd1, 15'h5555, 8'h00, 2'd0);
    issue(pfe_pkg::OP_RD,     7'd5, 8'd1, 15'h2aaa, 8'h00, 2'd0);
    // Mono palettes, including the ignored fourth slot.
    issue(pfe_pkg::OP_WR_MONO_CUR, 7'd0, 8'd0, 15'h0000, 8'h00, 2'd0);
    issue(pfe_pkg::OP_WR_MONO_CUR, 7'd0, 8'd0, 15'h0000, 8'hff, 2'd1);
    issue(pfe_pkg::OP_WR_MONO_CUR, 7'd0, 8'd0, 15'h0000, 8'he4, 2'd2);
    issue(pfe_pkg::OP_WR_MONO_TGT, 7'd0, 8'd0, 15'h0000, 8'hff, 2'd0);
    issue(pfe_pkg::OP_WR_MONO_TGT, 7'd0, 8'd0, 15'h0000, 8'h00, 2'd1);
    issue(pfe_pkg::OP_WR_MONO_TGT, 7'd0, 8'd0, 15'h0000, 8'h1b, 2'd2);
    issue(pfe_pkg::OP_WR_MONO_CUR, 7'd0, 8'd0, 15'h0000, 8'haa, 2'd3);
    issue(pfe_pkg::OP_WR_MONO_TGT, 7'd0, 8'd0, 15'h0000, 8'h55, 2'd3);
    issue(pfe_pkg::OP_FADE_MONO,   7'd0, 8'd0, 15'h0000, 8'h00, 2'd3);
    issue(pfe_pkg::OP_RD_MONO,     7'd0, 8'd0, 15'h0000, 8'h00, 2'd2);
    issue(pfe_pkg::OP_RD_MONO,     7'd0, 8'd0, 15'h0000, 8'h00, 2'd3);

    // Random phases, each at its own fade step: smallest, largest, zero, then others.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: value = 1;
        1: value = 31;
        2: value = 0;
        4: value = 16;
        default: value = $urandom_range(2, 30);
      endcase
      set_step(5'(value));
      calm = (p == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
    end

    drain();
    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb: %0d items: %0d writes, %0d color fades, %0d mono fades, %0d reads",
             op_seen.sum(),
             op_seen[pfe_pkg::OP_WR_CUR] + op_seen[pfe_pkg::OP_WR_TGT]
             + op_seen[pfe_pkg::OP_WR_MONO_CUR] + op_seen[pfe_pkg::OP_WR_MONO_TGT],
             op_seen[pfe_pkg::OP_FADE], op_seen[pfe_pkg::OP_FADE_MONO],
             op_seen[pfe_pkg::OP_RD] + op_seen[pfe_pkg::OP_RD_MONO]);
    $display("tb: %0d fade step settings; fades left entries off target %0d times, on %0d",
             step_settings, mirror.still_off, mirror.on_target);
    if (mirror.errors == 0 && mirror.owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
